[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock, ignored while reset is low.
`define MWHB_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("mwhb assertion failed");

// Check a property on the rising clock, also during reset.
`define MWHB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mwhb assertion failed");

`endif

[rtl/core/mwhb_pkg.sv]
// Shared types and constants of the hidden-bit word memory.
package mwhb_pkg;

    localparam int MEM_WORDS_DEF = 65536;
    localparam int LIMIT_W       = 18;
    localparam int IDX_W         = 24;
    localparam int WORD_IDX_W    = 22;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 18'h3ffff;
    localparam logic [7:0] HIDDEN_RESET = 8'h03;

    typedef enum logic [3:0] {
        OP_RD8      = 4'd0,
        OP_RD16     = 4'd1,
        OP_RD32     = 4'd2,
        OP_WR8      = 4'd3,
        OP_WR16     = 4'd4,
        OP_WR32     = 4'd5,
        OP_RDPAIR16 = 4'd6,
        OP_WRPAIR8  = 4'd7,
        OP_WRPAIR16 = 4'd8,
        OP_WRPAIR32 = 4'd9
    } t_op;

    typedef struct packed {
        logic [3:0]  op;
        logic [1:0]  lo;
        logic        ok;
        logic [31:0] wv;
        logic [7:0]  h0;
        logic [7:0]  h1;
    } t_req;

    typedef struct packed {
        logic        wr_en;
        logic [31:0] main_wdata;
        logic [15:0] hid_wdata;
        logic [31:0] read_data;
        logic [7:0]  hidden_data;
    } t_rsp;

endpackage

[rtl/core/memory_with_hidden_bits.sv]
// Top level of the word memory with a hidden byte per halfword.
//
// Each item is one access and returns one result item. In the cycle an item
// is accepted, the word and its pair of hidden bytes are read from the two
// RAMs; then, in ST_EXEC, the lanes are merged, written back and the result
// is loaded into the output register. No new item is taken until that
// read-modify-write is done. The next item is accepted while a result still
// waits in the output register; the merge cycle holds only when that register
// is still full. After reset a clearing pass fills main memory with zero and
// every hidden byte with 3; no item is accepted until it ends, configuration
// writes are taken at any time.
module memory_with_hidden_bits import mwhb_pkg::*; #(
    parameter int MEM_WORDS = MEM_WORDS_DEF,
    localparam int AW = $clog2(MEM_WORDS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [LIMIT_W-1:0] i_cfg_wr_data,   // last_byte_index
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [71:0]        s_axis_tdata,    // index, write_value, hidden_first, hidden_second
    input  logic [3:0]         s_axis_tuser,    // opcode
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [39:0]        m_axis_tdata     // read_data, hidden_data
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state             r_state;
    logic [AW-1:0]      r_clr;
    logic [LIMIT_W-1:0] r_limit;
    t_req               r_req;
    logic [AW-1:0]      r_addr;
    logic               r_out_valid;
    logic [39:0]        r_out_data;

    t_req          dec_req;
    logic [AW-1:0] dec_addr;
    t_rsp          rsp;
    logic [31:0]   main_rdata;
    logic [15:0]   hid_rdata;
    logic          accept;
    logic          out_free;
    logic          exec_done;
    logic          clearing;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   main_wdata;
    logic [15:0]   hid_wdata;

    mwhb_decode #(
        .MEM_WORDS(MEM_WORDS)
    ) u_decode (
        .i_opcode       (s_axis_tuser),
        .i_index        (s_axis_tdata[23:0]),
        .i_write_value  (s_axis_tdata[55:24]),
        .i_hidden_first (s_axis_tdata[63:56]),
        .i_hidden_second(s_axis_tdata[71:64]),
        .i_limit        (r_limit),
        .o_req          (dec_req),
        .o_addr         (dec_addr)
    );

    mwhb_merge u_merge (
        .i_req       (r_req),
        .i_main_rdata(main_rdata),
        .i_hid_rdata (hid_rdata),
        .o_rsp       (rsp)
    );

    always_comb begin
        clearing      = r_state == ST_CLEAR;
        s_axis_tready = r_state == ST_IDLE;
        accept        = s_axis_tvalid & s_axis_tready;
        out_free      = !r_out_valid | m_axis_tready;
        exec_done     = (r_state == ST_EXEC) & out_free;
        ram_we        = clearing | (exec_done & rsp.wr_en);
        ram_waddr     = clearing ? r_clr : r_addr;
        main_wdata    = clearing ? 32'd0 : rsp.main_wdata;
        hid_wdata     = clearing ? {HIDDEN_RESET, HIDDEN_RESET} : rsp.hid_wdata;
    end

    mwhb_ram #(
        .WIDTH(32),
        .DEPTH(MEM_WORDS)
    ) u_main_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(main_wdata),
        .i_re   (accept),
        .i_raddr(dec_addr),
        .o_rdata(main_rdata)
    );

    mwhb_ram #(
        .WIDTH(16),
        .DEPTH(MEM_WORDS)
    ) u_hidden_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(hid_wdata),
        .i_re   (accept),
        .i_raddr(dec_addr),
        .o_rdata(hid_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (m_axis_tready && !exec_done) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(MEM_WORDS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_req   <= dec_req;
                        r_addr  <= dec_addr;
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        r_out_data  <= {rsp.hidden_data, rsp.read_data};
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

[rtl/core/mwhb_ram.sv]
// Generic simple dual-port RAM with registered read.
module mwhb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/mwhb_decode.sv]
// Access decode: word address, lane bits and range check of one item.
module mwhb_decode import mwhb_pkg::*; #(
    parameter int MEM_WORDS = MEM_WORDS_DEF,
    localparam int AW = $clog2(MEM_WORDS)
) (
    input  logic [3:0]         i_opcode,
    input  logic [IDX_W-1:0]   i_index,
    input  logic [31:0]        i_write_value,
    input  logic [7:0]         i_hidden_first,
    input  logic [7:0]         i_hidden_second,
    input  logic [LIMIT_W-1:0] i_limit,
    output t_req               o_req,
    output logic [AW-1:0]      o_addr
);

    logic [WORD_IDX_W-1:0] word;
    logic                  lim_ok;
    logic                  word_ok;

    always_comb begin
        word   = i_index[WORD_IDX_W-1:0];
        lim_ok = 1'b0;
        unique case (t_op'(i_opcode))
            OP_RD8, OP_WR8, OP_WRPAIR8: begin
                word   = i_index[IDX_W-1:2];
                lim_ok = i_index <= IDX_W'(i_limit);
            end
            OP_RD16, OP_WR16, OP_RDPAIR16, OP_WRPAIR16: begin
                word   = i_index[IDX_W-2:1];
                lim_ok = i_index[IDX_W-2:0] <= (IDX_W-1)'(i_limit[LIMIT_W-1:1]);
            end
            OP_RD32, OP_WR32, OP_WRPAIR32: begin
                word   = i_index[WORD_IDX_W-1:0];
                lim_ok = i_index[WORD_IDX_W-1:0] <= WORD_IDX_W'(i_limit[LIMIT_W-1:2]);
            end
            default: begin
                lim_ok = 1'b0;
            end
        endcase
        word_ok = {1'b0, word} < (WORD_IDX_W+1)'(MEM_WORDS);

        o_req.op = i_opcode;
        o_req.lo = i_index[1:0];
        o_req.ok = lim_ok & word_ok;
        o_req.wv = i_write_value;
        o_req.h0 = i_hidden_first;
        o_req.h1 = i_hidden_second;
        o_addr   = word[AW-1:0];
    end

endmodule

[rtl/core/mwhb_merge.sv]
// Lane extract and read-modify-write merge of one access.
module mwhb_merge import mwhb_pkg::*; (
    input  t_req        i_req,
    input  logic [31:0] i_main_rdata,
    input  logic [15:0] i_hid_rdata,
    output t_rsp        o_rsp
);

    logic [4:0]  s8;
    logic [4:0]  s16;
    logic [31:0] m8;
    logic [31:0] m16;
    logic [31:0] wr8;
    logic [31:0] wr16;
    logic [7:0]  hid_even;
    logic [7:0]  hid_odd;

    always_comb begin
        s8   = {~i_req.lo, 3'b000};
        s16  = i_req.lo[0] ? 5'd0 : 5'd16;
        m8   = 32'h0000_00ff << s8;
        m16  = 32'h0000_ffff << s16;
        wr8  = (i_main_rdata & ~m8) | ((32'(i_req.wv[7:0])) << s8);
        wr16 = (i_main_rdata & ~m16) | ((32'(i_req.wv[15:0])) << s16);
        hid_even = i_hid_rdata[15:8];
        hid_odd  = i_hid_rdata[7:0];

        o_rsp.wr_en       = 1'b0;
        o_rsp.main_wdata  = i_main_rdata;
        o_rsp.hid_wdata   = i_hid_rdata;
        o_rsp.read_data   = '0;
        o_rsp.hidden_data = '0;

        unique case (t_op'(i_req.op))
            OP_RD8: begin
                o_rsp.read_data = 32'((i_main_rdata >> s8) & 32'h0000_00ff);
            end
            OP_RD16: begin
                o_rsp.read_data = 32'((i_main_rdata >> s16) & 32'h0000_ffff);
            end
            OP_RD32: begin
                o_rsp.read_data = i_main_rdata;
            end
            OP_RDPAIR16: begin
                o_rsp.read_data   = 32'((i_main_rdata >> s16) & 32'h0000_ffff);
                o_rsp.hidden_data = i_req.lo[0] ? hid_odd : hid_even;
            end
            OP_WR8: begin
                o_rsp.wr_en      = 1'b1;
                o_rsp.main_wdata = wr8;
            end
            OP_WR16: begin
                o_rsp.wr_en      = 1'b1;
                o_rsp.main_wdata = wr16;
            end
            OP_WR32: begin
                o_rsp.wr_en      = 1'b1;
                o_rsp.main_wdata = i_req.wv;
            end
            OP_WRPAIR8: begin
                o_rsp.wr_en      = 1'b1;
                o_rsp.main_wdata = wr8;
                if (i_req.lo[0]) begin
                    o_rsp.hid_wdata = i_req.lo[1] ? {hid_even, i_req.h0}
                                                  : {i_req.h0, hid_odd};
                end
            end
            OP_WRPAIR16: begin
                o_rsp.wr_en      = 1'b1;
                o_rsp.main_wdata = wr16;
                o_rsp.hid_wdata  = i_req.lo[0] ? {hid_even, i_req.h0}
                                               : {i_req.h0, hid_odd};
            end
            OP_WRPAIR32: begin
                o_rsp.wr_en      = 1'b1;
                o_rsp.main_wdata = i_req.wv;
                o_rsp.hid_wdata  = {i_req.h0, i_req.h1};
            end
            default: begin
                o_rsp.wr_en = 1'b0;
            end
        endcase

        if (!i_req.ok) begin
            o_rsp.wr_en       = 1'b0;
            o_rsp.read_data   = '0;
            o_rsp.hidden_data = '0;
        end
    end

endmodule

[rtl/core/mwhb_checker.sv]
// Port-level assertions for the hidden-bit word memory, bound to the top level.
`include "assert_macros.svh"

module mwhb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    logic in_take;
    logic out_stall;

    assign in_take   = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    `MWHB_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata))
    `MWHB_ASSERT(a_one_at_a_time, i_clk, i_rst_n, in_take |=> !s_axis_tready)
    `MWHB_ASSERT(a_result_due, i_clk, i_rst_n, in_take |=> ##1 m_axis_tvalid)
    `MWHB_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> (!s_axis_tready && !m_axis_tvalid))

endmodule

bind memory_with_hidden_bits mwhb_checker u_mwhb_checker (.*);
